@@ rtl/core/bsfp_pkg.sv @@
// Package for the binary sample frame parser.
// Holds field kinds, format codes, register indexes, missing codes and the
// record and status types shared by the front end, queue, back end and top.
`default_nettype none

package bsfp_pkg;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_TIME   = 2'd1,
    KIND_ANALOG = 2'd2,
    KIND_STATUS = 2'd3
  } fld_kind_t;

  typedef enum logic [1:0] {
    FMT_INT16 = 2'd0,
    FMT_INT32 = 2'd1,
    FMT_FLOAT = 2'd2,
    FMT_ALT   = 2'd3
  } data_fmt_t;

  typedef enum logic [2:0] {
    REG_FORMAT     = 3'd0,
    REG_ANALOG_CNT = 3'd1,
    REG_STATUS_CNT = 3'd2,
    REG_REV_YEAR   = 3'd3,
    REG_MAX_FRAMES = 3'd4
  } cfg_addr_t;

  localparam logic [11:0] REV_YEAR_RESET = 12'd1999;
  localparam logic [11:0] REV_YEAR_OLD   = 12'd1991;
  localparam logic [15:0] MISS16_OLD     = 16'hFFFF;
  localparam logic [15:0] MISS16_NEW     = 16'h8000;
  localparam logic [31:0] MISS32         = 32'h8000_0000;
  localparam logic [31:0] FLT_EXP_MASK   = 32'h7F80_0000;
  localparam logic [31:0] FLT_LOWEST     = 32'hFF7F_FFFF;
  localparam logic [31:0] WORD_BITS_LAST = 32'd15;
  localparam logic [31:0] WORD_BITS      = 32'd16;
  localparam int          FIFO_DEPTH     = 2;

  typedef struct packed {
    logic [1:0]  fmt_code;
    logic [8:0]  n_analog;
    logic [10:0] n_status;
    logic [11:0] rev_year;
    logic [31:0] frame_limit;
  } cfg_t;

  typedef struct packed {
    fld_kind_t   kind;
    logic [9:0]  idx;
    logic [31:0] value;
    logic        last;
  } fld_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/binary_sample_frame_parser_unit.sv @@
// Binary sample frame parser: one byte per beat in, one field result per beat out.
// Takes one byte every cycle while the record queue is not full; each result
// passes through the queue and an output register. The front end updates its
// counters on each byte, and the two-entry record queue keeps both sides moving.
// Synchronous active-low reset clears all control state and loads register
// defaults (revision year 1999, all others zero); no clearing pass is needed.
`default_nettype none

module binary_sample_frame_parser_unit #(
  parameter int MAX_ANALOG = 256,
  parameter int MAX_STATUS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [9:0] channel_index, [41:10] field_value
  output logic [2:0]       out_tuser,  // [1:0] field_kind, [2] value_missing
  output logic             out_tlast,  // frame_end
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata
);
  import bsfp_pkg::*;

  cfg_t       cfg_r;
  logic       accept;
  logic       push;
  logic       pop;
  fld_rec_t   wr_rec;
  fld_rec_t   rd_rec;
  fifo_stat_t fifo_stat;
  fld_rec_t   out_rec;
  logic       out_missing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fmt_code    <= 2'd0;
      cfg_r.n_analog    <= 9'd0;
      cfg_r.n_status    <= 11'd0;
      cfg_r.rev_year    <= REV_YEAR_RESET;
      cfg_r.frame_limit <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FORMAT:     cfg_r.fmt_code    <= cfg_wdata[1:0];
        REG_ANALOG_CNT: cfg_r.n_analog    <= cfg_wdata[8:0];
        REG_STATUS_CNT: cfg_r.n_status    <= cfg_wdata[10:0];
        REG_REV_YEAR:   cfg_r.rev_year    <= cfg_wdata[11:0];
        REG_MAX_FRAMES: cfg_r.frame_limit <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_tready = !fifo_stat.full;
  assign accept    = in_tvalid && in_tready;

  bsfp_front #(
    .MAX_ANALOG(MAX_ANALOG),
    .MAX_STATUS(MAX_STATUS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .accept   (accept),
    .data_byte(in_tdata),
    .push     (push),
    .rec      (wr_rec)
  );

  bsfp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wr_rec(wr_rec),
    .pop   (pop),
    .rd_rec(rd_rec),
    .stat  (fifo_stat)
  );

  bsfp_back #(
    .MAX_STATUS(MAX_STATUS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .rd_rec     (rd_rec),
    .rec_avail  (!fifo_stat.empty),
    .pop        (pop),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_rec    (out_rec),
    .out_missing(out_missing)
  );

  assign out_tdata = {6'd0, out_rec.value, out_rec.idx};
  assign out_tuser = {out_missing, out_rec.kind};
  assign out_tlast = out_rec.last;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_stat.full)
    else $error("record queue written while full");

  a_miss_analog_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != KIND_ANALOG |-> !out_tuser[2])
    else $error("missing mark on a non-analog field");

  a_no_end_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == KIND_SAMPLE |-> !out_tlast)
    else $error("frame end flagged on a sample number");
`endif

endmodule

`default_nettype wire

@@ rtl/core/bsfp_front.sv @@
// Front end of the frame parser: gathers bytes into fields and tracks frames.
// Emits one raw field record per completed field. Uses bsfp_pkg.
`default_nettype none

module bsfp_front #(
  parameter int MAX_ANALOG = 256,
  parameter int MAX_STATUS = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bsfp_pkg::cfg_t   cfg,
  input  wire logic             accept,
  input  wire logic [7:0]       data_byte,
  output logic                  push,
  output bsfp_pkg::fld_rec_t    rec
);
  import bsfp_pkg::*;

  localparam int CNT_MAX = (MAX_ANALOG > MAX_STATUS / 16) ? MAX_ANALOG : MAX_STATUS / 16;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  logic [1:0]       byte_pos_r, byte_pos_nxt;
  fld_kind_t        phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      asm_r, asm_nxt;
  logic [31:0]      frames_r, frames_nxt;
  logic             stopped_r, stopped_nxt;

  logic [31:0] word;
  logic [31:0] cnt_inc;
  logic [31:0] cnt_ext;
  logic [31:0] eff_analog;
  logic [31:0] stat_bits;
  logic [31:0] eff_words;
  logic [1:0]  last_pos;
  logic        done;
  logic        frame_end;

  always_comb begin
    word       = asm_r | ({24'd0, data_byte} << {byte_pos_r, 3'b000});
    cnt_ext    = 32'(cnt_r);
    cnt_inc    = cnt_ext + 32'd1;
    eff_analog = ({23'd0, cfg.n_analog} > 32'(MAX_ANALOG)) ?
                 32'(MAX_ANALOG) : {23'd0, cfg.n_analog};
    stat_bits  = ({21'd0, cfg.n_status} > 32'(MAX_STATUS)) ?
                 32'(MAX_STATUS) : {21'd0, cfg.n_status};
    eff_words  = (stat_bits + WORD_BITS_LAST) >> 4;

    if (phase_r == KIND_STATUS ||
        (phase_r == KIND_ANALOG && cfg.fmt_code == FMT_INT16)) begin
      last_pos = 2'd1;
    end else begin
      last_pos = 2'd3;
    end
    done = byte_pos_r >= last_pos;

    byte_pos_nxt = byte_pos_r;
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    asm_nxt      = asm_r;
    frames_nxt   = frames_r;
    stopped_nxt  = stopped_r;
    frame_end    = 1'b0;
    push         = 1'b0;

    rec.kind  = phase_r;
    rec.idx   = 10'd0;
    rec.value = word;
    rec.last  = 1'b0;

    if (accept && !stopped_r) begin
      if (!done) begin
        byte_pos_nxt = byte_pos_r + 2'd1;
        asm_nxt      = word;
      end else begin
        push         = 1'b1;
        byte_pos_nxt = 2'd0;
        asm_nxt      = 32'd0;
        case (phase_r)
          KIND_SAMPLE: begin
            phase_nxt = KIND_TIME;
          end
          KIND_TIME: begin
            cnt_nxt = '0;
            if (eff_analog != 32'd0) begin
              phase_nxt = KIND_ANALOG;
            end else if (eff_words != 32'd0) begin
              phase_nxt = KIND_STATUS;
            end else begin
              frame_end = 1'b1;
            end
          end
          KIND_ANALOG: begin
            rec.idx = cnt_ext[9:0];
            cnt_nxt = cnt_inc[CNT_W-1:0];
            if (cnt_inc >= eff_analog) begin
              cnt_nxt = '0;
              if (eff_words != 32'd0) begin
                phase_nxt = KIND_STATUS;
              end else begin
                frame_end = 1'b1;
              end
            end
          end
          KIND_STATUS: begin
            rec.idx = cnt_ext[9:0];
            cnt_nxt = cnt_inc[CNT_W-1:0];
            if (cnt_inc >= eff_words) begin
              frame_end = 1'b1;
            end
          end
          default: begin
            phase_nxt = KIND_SAMPLE;
          end
        endcase
        if (frame_end) begin
          phase_nxt  = KIND_SAMPLE;
          cnt_nxt    = '0;
          frames_nxt = frames_r + 32'd1;
          if (cfg.frame_limit != 32'd0 && frames_nxt >= cfg.frame_limit) begin
            stopped_nxt = 1'b1;
          end
        end
      end
    end
    rec.last = frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= 2'd0;
      phase_r    <= KIND_SAMPLE;
      cnt_r      <= '0;
      asm_r      <= 32'd0;
      frames_r   <= 32'd0;
      stopped_r  <= 1'b0;
    end else begin
      byte_pos_r <= byte_pos_nxt;
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      asm_r      <= asm_nxt;
      frames_r   <= frames_nxt;
      stopped_r  <= stopped_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bsfp_fifo.sv @@
// Short record queue between the front end and the back end.
// Stores raw field records; uses bsfp_pkg for the record and status types.
`default_nettype none

module bsfp_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire bsfp_pkg::fld_rec_t wr_rec,
  input  wire logic               pop,
  output bsfp_pkg::fld_rec_t      rd_rec,
  output bsfp_pkg::fifo_stat_t    stat
);
  import bsfp_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  fld_rec_t         mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (32'(p) == 32'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
    stat.full  = 32'(count_r) == 32'(FIFO_DEPTH);
    stat.empty = count_r == '0;
    rd_rec     = mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bsfp_back.sv @@
// Back end of the frame parser: finishes each field record and holds the result.
// Applies sign extension, missing-code checks and status masking. Uses bsfp_pkg.
`default_nettype none

module bsfp_back #(
  parameter int MAX_STATUS = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bsfp_pkg::cfg_t     cfg,
  input  wire bsfp_pkg::fld_rec_t rd_rec,
  input  wire logic               rec_avail,
  output logic                    pop,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output bsfp_pkg::fld_rec_t      out_rec,
  output logic                    out_missing
);
  import bsfp_pkg::*;

  logic     valid_r, valid_nxt;
  fld_rec_t rec_r;
  logic     miss_r;

  fld_rec_t fin_rec;
  logic     fin_miss;
  logic [15:0] lo;
  logic [15:0] miss16;
  logic [31:0] stat_bits;
  logic [31:0] base;
  logic [31:0] left;
  logic [31:0] mask;

  always_comb begin
    fin_rec   = rd_rec;
    fin_miss  = 1'b0;
    lo        = rd_rec.value[15:0];
    miss16    = (cfg.rev_year <= REV_YEAR_OLD) ? MISS16_OLD : MISS16_NEW;
    stat_bits = ({21'd0, cfg.n_status} > 32'(MAX_STATUS)) ?
                32'(MAX_STATUS) : {21'd0, cfg.n_status};
    base      = {18'd0, rd_rec.idx, 4'b0000};
    left      = (stat_bits > base) ? stat_bits - base : 32'd0;
    mask      = (left >= WORD_BITS) ? 32'h0000_FFFF : ((32'd1 << left[3:0]) - 32'd1);

    case (rd_rec.kind)
      KIND_ANALOG: begin
        case (cfg.fmt_code)
          FMT_INT16: begin
            fin_miss      = lo == miss16;
            fin_rec.value = {{16{lo[15]}}, lo};
          end
          FMT_INT32: begin
            fin_miss = rd_rec.value == MISS32;
          end
          default: begin
            fin_miss = ((rd_rec.value & FLT_EXP_MASK) == FLT_EXP_MASK) ||
                       (rd_rec.value == FLT_LOWEST);
          end
        endcase
      end
      KIND_STATUS: begin
        fin_rec.value = rd_rec.value & mask;
      end
      default: begin
        fin_miss = 1'b0;
      end
    endcase

    pop       = rec_avail && (!valid_r || out_ready);
    valid_nxt = pop || (valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec_r  <= fin_rec;
      miss_r <= fin_miss;
    end
  end

  assign out_valid   = valid_r;
  assign out_rec     = rec_r;
  assign out_missing = miss_r;

endmodule

`default_nettype wire
